// ===== hw/rtl/remote_keyed_countdown_timer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rkct assertion macros
// shared concurrent check forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef REMOTE_KEYED_COUNTDOWN_TIMER_UNIT_MACROS_SVH
`define REMOTE_KEYED_COUNTDOWN_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define RKCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RKCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rkct_pkg.sv =====
// ----------------------------------------------------------------------------
// rkct_pkg
// shared types, register indexes and helpers of the countdown timer
// ----------------------------------------------------------------------------
package rkct_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_MS_TICK = 2'd0,
    OP_CD_TICK = 2'd1,
    OP_CODE    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_DISCARD  = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic [2:0] REG_STORED_CODE     = 3'd0;
  localparam logic [2:0] REG_COOLDOWN_RELOAD = 3'd1;
  localparam logic [2:0] REG_TICKS_PER_SEC   = 3'd2;
  localparam logic [2:0] REG_SHORT_PRESET    = 3'd3;
  localparam logic [2:0] REG_LONG_PRESET     = 3'd4;

  // key field of a remote code
  localparam logic [1:0] KEY_SHORT = 2'd1;
  localparam logic [1:0] KEY_LONG  = 2'd2;
  localparam logic [1:0] KEY_PAUSE = 2'd3;
  localparam logic [31:0] ID_MASK  = 32'hFFFC_FFFF;

  localparam logic [6:0] MAX_SECONDS = 7'd99;

  // reset values
  localparam logic [31:0] RST_STORED_CODE     = 32'd0;
  localparam logic [15:0] RST_COOLDOWN_RELOAD = 16'd3000;
  localparam logic [9:0]  RST_TICKS_PER_SEC   = 10'd1000;
  localparam logic [6:0]  RST_SHORT_PRESET    = 7'd14;
  localparam logic [6:0]  RST_LONG_PRESET     = 7'd24;

  typedef struct packed {
    logic [31:0] stored_code;
    logic [15:0] cooldown_reload;
    logic [9:0]  ticks_per_second;
    logic [6:0]  short_preset;
    logic [6:0]  long_preset;
  } cfg_t;

  typedef struct packed {
    logic [6:0] remaining_seconds;
    logic       display_strobe;
    logic       running;
    status_e    code_status;
  } result_t;

  // tens of a value below 128: multiply by 205/2048
  function automatic logic [3:0] bcd_tens(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] bcd_units(input logic [6:0] v);
    logic [6:0] t10;
    logic [6:0] r;
    t10 = 7'(bcd_tens(v)) * 7'd10;
    r   = v - t10;
    return r[3:0];
  endfunction

endpackage

// ===== hw/rtl/rkct_in_if.sv =====
// ----------------------------------------------------------------------------
// rkct_in_if
// input word channel: operation and received remote code
// ----------------------------------------------------------------------------
interface rkct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] rf_code;

  modport source (output valid, output operation, output rf_code, input ready);
  modport sink   (input valid, input operation, input rf_code, output ready);
endinterface

// ===== hw/rtl/rkct_out_if.sv =====
// ----------------------------------------------------------------------------
// rkct_out_if
// result word channel: remaining seconds, digits and status
// ----------------------------------------------------------------------------
interface rkct_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] remaining_seconds;
  logic [3:0] tens_digit;
  logic [3:0] units_digit;
  logic       display_strobe;
  logic       running;
  logic [1:0] code_status;

  modport source (output valid, output remaining_seconds, output tens_digit,
                  output units_digit, output display_strobe, output running,
                  output code_status, input ready);
  modport sink   (input valid, input remaining_seconds, input tens_digit,
                  input units_digit, input display_strobe, input running,
                  input code_status, output ready);
endinterface

// ===== hw/rtl/rkct_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rkct_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
interface rkct_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rkct_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rkct_cfg_regs
// configuration register file, written one word per handshake
// ----------------------------------------------------------------------------
module rkct_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  rkct_cfg_if.sink      cfg_i,
  output rkct_pkg::cfg_t cfg_o
);
  import rkct_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_i.index)
        REG_STORED_CODE:     cfg_d.stored_code      = cfg_i.data;
        REG_COOLDOWN_RELOAD: cfg_d.cooldown_reload  = cfg_i.data[15:0];
        REG_TICKS_PER_SEC:   cfg_d.ticks_per_second = cfg_i.data[9:0];
        REG_SHORT_PRESET:    cfg_d.short_preset     = cfg_i.data[6:0];
        REG_LONG_PRESET:     cfg_d.long_preset      = cfg_i.data[6:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stored_code      <= RST_STORED_CODE;
      cfg_q.cooldown_reload  <= RST_COOLDOWN_RELOAD;
      cfg_q.ticks_per_second <= RST_TICKS_PER_SEC;
      cfg_q.short_preset     <= RST_SHORT_PRESET;
      cfg_q.long_preset      <= RST_LONG_PRESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== hw/rtl/rkct_core.sv =====
// ----------------------------------------------------------------------------
// rkct_core
// timer state and its combinational update for one word
// ----------------------------------------------------------------------------
module rkct_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rkct_pkg::cfg_t   cfg_i,
  input  logic             step_i,
  input  logic [1:0]       operation_i,
  input  logic [31:0]      rf_code_i,
  output rkct_pkg::result_t result_o
);
  import rkct_pkg::*;

  logic [6:0]  seconds_q, seconds_d;
  logic [9:0]  sub_q, sub_d;
  logic        run_q, run_d;
  logic        started_q, started_d;
  logic [15:0] cooldown_q, cooldown_d;

  logic [9:0]  sub_inc;
  logic [6:0]  sec_dec;
  logic [6:0]  preset_sel;
  logic [6:0]  preset_sat;
  logic [1:0]  key;
  logic        id_match;
  logic        strobe;
  status_e     status;

  assign sub_inc    = sub_q + 10'd1;
  assign sec_dec    = (seconds_q != 7'd0) ? seconds_q - 7'd1 : seconds_q;
  assign key        = rf_code_i[17:16];
  assign id_match   = (rf_code_i & ID_MASK) == (cfg_i.stored_code & ID_MASK);
  assign preset_sel = (key == KEY_LONG) ? cfg_i.long_preset : cfg_i.short_preset;
  assign preset_sat = (preset_sel > MAX_SECONDS) ? MAX_SECONDS : preset_sel;

  always_comb begin
    seconds_d  = seconds_q;
    sub_d      = sub_q;
    run_d      = run_q;
    started_d  = started_q;
    cooldown_d = cooldown_q;
    strobe     = 1'b0;
    status     = ST_NONE;
    case (op_e'(operation_i))
      OP_MS_TICK: begin
        if (run_q) begin
          if (sub_inc >= cfg_i.ticks_per_second) begin
            sub_d     = 10'd0;
            seconds_d = sec_dec;
            strobe    = (seconds_q != 7'd0);
            // second boundary that lands on zero stops the count
            if (sec_dec == 7'd0) begin
              run_d     = 1'b0;
              started_d = 1'b0;
            end
          end else begin
            sub_d = sub_inc;
          end
        end
      end
      OP_CD_TICK: begin
        if (cooldown_q != 16'd0) cooldown_d = cooldown_q - 16'd1;
      end
      OP_CODE: begin
        if (cooldown_q != 16'd0) begin
          status = ST_DISCARD;
        end else begin
          cooldown_d = cfg_i.cooldown_reload;
          if (id_match) begin
            status = ST_MATCH;
            if (key == KEY_SHORT || key == KEY_LONG) begin
              seconds_d = preset_sat;
              sub_d     = 10'd0;
              started_d = 1'b1;
              run_d     = 1'b1;
              strobe    = 1'b1;
            end else if (key == KEY_PAUSE && started_q) begin
              run_d = !run_q;
            end
          end else begin
            status = ST_MISMATCH;
          end
        end
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q  <= 7'd0;
      sub_q      <= 10'd0;
      run_q      <= 1'b0;
      started_q  <= 1'b0;
      cooldown_q <= 16'd0;
    end else if (step_i) begin
      seconds_q  <= seconds_d;
      sub_q      <= sub_d;
      run_q      <= run_d;
      started_q  <= started_d;
      cooldown_q <= cooldown_d;
    end
  end

  assign result_o.remaining_seconds = seconds_d;
  assign result_o.display_strobe    = strobe;
  assign result_o.running           = run_d;
  assign result_o.code_status       = status;
endmodule

// ===== hw/rtl/remote_keyed_countdown_timer_unit.sv =====
// ----------------------------------------------------------------------------
// remote_keyed_countdown_timer_unit: remote-keyed seconds countdown timer
// path: input handshake to result valid passes the input reg, then the result reg
// throughput: one word per cycle while the sink keeps ready; the state update is combinational
// reset: async active low; state, flags and valids clear, registers take defaults
// ----------------------------------------------------------------------------
module remote_keyed_countdown_timer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rkct_cfg_if.sink  cfg_i,
  rkct_in_if.sink   in_i,
  rkct_out_if.source out_o
);
  import rkct_pkg::*;
  `include "remote_keyed_countdown_timer_unit_macros.svh"

  cfg_t    cfg;
  result_t res_d;
  result_t res_q;

  // input register stage
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_op_q;
  logic [31:0] s1_code_q;
  logic        in_acc;
  logic        s1_adv;

  // result register stage
  logic out_valid_q, out_valid_d;

  // stage 1 moves on whenever the result register is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_i.operation;
      s1_code_q <= in_i.rf_code;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  rkct_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // timer state commits exactly when the word enters the result register
  rkct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (s1_adv),
    .operation_i (s1_op_q),
    .rf_code_i   (s1_code_q),
    .result_o    (res_d)
  );

  // digits come straight off the result register
  assign out_o.valid             = out_valid_q;
  assign out_o.remaining_seconds = res_q.remaining_seconds;
  assign out_o.tens_digit        = bcd_tens(res_q.remaining_seconds);
  assign out_o.units_digit       = bcd_units(res_q.remaining_seconds);
  assign out_o.display_strobe    = res_q.display_strobe;
  assign out_o.running           = res_q.running;
  assign out_o.code_status       = res_q.code_status;

  // stall only when both stages hold words and the sink holds off
  `RKCT_ASSERT_NOW(a_ready_stall, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready, "input stalled without a full pipe")
  // a word in stage 1 that cannot move must still be there next cycle
  `RKCT_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q, "stage 1 word lost")
  // a discarded code never touches the display
  `RKCT_ASSERT_NOW(a_discard_quiet, out_valid_q && res_q.code_status == ST_DISCARD, !res_q.display_strobe, "strobe on discarded code")
  // digits agree with the binary count
  `RKCT_ASSERT_NOW(a_bcd, out_valid_q, 7'(out_o.tens_digit) * 7'd10 + 7'(out_o.units_digit) == out_o.remaining_seconds, "bcd digits disagree")
endmodule
